// ===== rtl/dshc_pkg.sv =====
// ----------------------------------------------------------------------------
// Differential drive controller package
// Shared types, configuration layout and the control program of the
// speed and heading controller.
// ----------------------------------------------------------------------------
package dshc_pkg;

  // Item field widths.
  localparam int unsigned GainW   = 22;
  localparam int unsigned AlphaW  = 17;
  localparam int unsigned YawW    = 15;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned IntegW  = 11;
  localparam int unsigned OpAW    = 23;
  localparam int unsigned OpBW    = 19;
  localparam int unsigned ProdW   = 42;
  localparam int unsigned StepW   = 4;
  localparam int unsigned CfgIdxW = 3;

  typedef logic [StepW-1:0] step_t;

  localparam step_t StepFirst = 4'd1;
  localparam step_t StepLast  = 4'd8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_SPEED_KP       = 3'd0,
    REG_SPEED_KI       = 3'd1,
    REG_FILTER_ALPHA   = 3'd2,
    REG_HEADING_KP     = 3'd3,
    REG_HEADING_KD     = 3'd4,
    REG_HEADING_TARGET = 3'd5,
    REG_DRIVE_UPPER    = 3'd6,
    REG_DRIVE_LOWER    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [GainW-1:0]  speed_kp;
    logic        [GainW-1:0]  speed_ki;
    logic        [AlphaW-1:0] filter_alpha;
    logic        [GainW-1:0]  heading_kp;
    logic        [GainW-1:0]  heading_kd;
    logic signed [YawW-1:0]   heading_target;
    logic signed [WordW-1:0]  drive_upper;
    logic signed [WordW-1:0]  drive_lower;
  } cfg_t;

  typedef struct packed {
    logic signed [WordW-1:0] speed_target;
    logic signed [WordW-1:0] count_left;
    logic signed [WordW-1:0] count_right;
    logic signed [YawW-1:0]  yaw_now;
  } in_item_t;

  typedef struct packed {
    logic signed [WordW-1:0] drive_left;
    logic signed [WordW-1:0] drive_right;
    logic signed [WordW-1:0] speed_term;
    logic signed [WordW-1:0] turn_term;
  } out_item_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [2:0] {
    MUL_ERR_NEW  = 3'd0,  // (1 - alpha) * raw speed error
    MUL_FILT_OLD = 3'd1,  // alpha * previous filtered error
    MUL_HKP_ERR  = 3'd2,  // heading kp * heading error
    MUL_HKD_DIFF = 3'd3,  // heading kd * heading error difference
    MUL_SKP_FILT = 3'd4,  // speed kp * filtered error
    MUL_SKI_INT  = 3'd5   // speed ki * integral
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_e;

  typedef enum logic [2:0] {
    WB_NONE  = 3'd0,
    WB_FILT  = 3'd1,
    WB_INTEG = 3'd2,
    WB_TURN  = 3'd3,
    WB_OUT   = 3'd4
  } wb_e;

  typedef enum logic [1:0] {
    JMP_NEXT    = 2'd0,  // go to the following step
    JMP_WAIT_IN = 2'd1,  // hold until an item is taken, then advance
    JMP_DONE    = 2'd2   // hold until the output slot is free, then jump
  } jmp_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    wb_e      wb;
    jmp_e     jmp;
    step_t    target;
  } uword_t;

  // Control signals from the sequencer to the datapath.
  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    wb_e      wb;
  } ctl_t;

  // Control program. The multiplier result is registered, so an ACC
  // operation consumes the product selected in the previous step.
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{MUL_ERR_NEW, ACC_HOLD, WB_NONE, JMP_NEXT, '0};
    unique case (s)
      4'd0: w = '{MUL_ERR_NEW,  ACC_HOLD, WB_NONE,  JMP_WAIT_IN, '0};
      4'd1: w = '{MUL_ERR_NEW,  ACC_HOLD, WB_NONE,  JMP_NEXT,    '0};
      4'd2: w = '{MUL_FILT_OLD, ACC_LOAD, WB_NONE,  JMP_NEXT,    '0};
      4'd3: w = '{MUL_HKP_ERR,  ACC_ADD,  WB_NONE,  JMP_NEXT,    '0};
      4'd4: w = '{MUL_HKD_DIFF, ACC_LOAD, WB_FILT,  JMP_NEXT,    '0};
      4'd5: w = '{MUL_SKP_FILT, ACC_ADD,  WB_INTEG, JMP_NEXT,    '0};
      4'd6: w = '{MUL_SKI_INT,  ACC_LOAD, WB_TURN,  JMP_NEXT,    '0};
      4'd7: w = '{MUL_SKI_INT,  ACC_ADD,  WB_NONE,  JMP_NEXT,    '0};
      4'd8: w = '{MUL_SKI_INT,  ACC_HOLD, WB_OUT,   JMP_DONE,    '0};
      default: w = '{MUL_ERR_NEW, ACC_HOLD, WB_NONE, JMP_DONE, '0};
    endcase
    return w;
  endfunction

  // Saturate a 26-bit signed value to 16 bits.
  function automatic logic signed [WordW-1:0] sat16(logic signed [25:0] x);
    logic signed [WordW-1:0] r;
    if (x > 26'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -26'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = x[WordW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/dshc_datapath.sv =====
// ----------------------------------------------------------------------------
// Controller datapath
// Shared multiplier, accumulator and controller state, steered by the
// control word of the sequencer.
// ----------------------------------------------------------------------------
module dshc_datapath #(
  parameter int IntegralLimit = 1000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dshc_pkg::ctl_t      ctl_i,
  input  dshc_pkg::cfg_t      cfg_i,
  input  dshc_pkg::in_item_t  item_i,
  output dshc_pkg::out_item_t result_o
);
  import dshc_pkg::*;

  localparam logic signed [OpBW-1:0] LimPos = OpBW'(IntegralLimit);
  localparam logic signed [OpBW-1:0] LimNeg = -LimPos;
  localparam logic signed [WordW-1:0] HalfTurn = 16'sd11520;
  localparam logic signed [WordW-1:0] FullTurn = 16'sd23040;
  localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;

  // Controller state.
  logic signed [ErrW-1:0]   filt_q;
  logic signed [IntegW-1:0] integ_q;
  logic signed [YawW-1:0]   prev_e_q;

  // Per-item working registers.
  logic signed [ErrW-1:0]  err_q;
  logic signed [YawW-1:0]  e_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] acc_q;
  logic signed [WordW-1:0] t_q;

  logic [AlphaW-1:0]       alpha;
  logic [AlphaW-1:0]       alpha_inv;
  logic signed [WordW-1:0] e_diff;
  logic signed [WordW-1:0] e_raw;
  logic signed [WordW-1:0] e_wrap;
  logic signed [ErrW-1:0]  err_new;
  logic signed [OpAW-1:0]  op_a;
  logic signed [OpBW-1:0]  op_b;
  logic signed [ProdW-1:0] acc_bias16;
  logic signed [ProdW-1:0] acc_bias22;
  logic signed [OpBW-1:0]  integ_sum;
  logic signed [IntegW-1:0] integ_new;
  logic signed [WordW-1:0] v_sat;
  logic signed [WordW:0]   left_w;
  logic signed [WordW:0]   right_w;
  logic signed [WordW:0]   upper_w;
  logic signed [WordW:0]   lower_w;
  logic signed [WordW:0]   left_hi;
  logic signed [WordW:0]   right_hi;
  logic signed [WordW:0]   left_c;
  logic signed [WordW:0]   right_c;

  // Alpha above one acts as one.
  assign alpha     = (cfg_i.filter_alpha > AlphaOne) ? AlphaOne : cfg_i.filter_alpha;
  assign alpha_inv = AlphaOne - alpha;

  assign err_new = ErrW'(item_i.count_left) + ErrW'(item_i.count_right)
                 + ErrW'(item_i.speed_target);

  // Heading error wrapped into one half turn either way.
  assign e_raw = WordW'(cfg_i.heading_target) - WordW'(item_i.yaw_now);
  always_comb begin
    if (e_raw > HalfTurn) begin
      e_wrap = e_raw - FullTurn;
    end else if (e_raw < -HalfTurn) begin
      e_wrap = e_raw + FullTurn;
    end else begin
      e_wrap = e_raw;
    end
  end

  assign e_diff = WordW'(e_q) - WordW'(prev_e_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl_i.mul_sel)
      MUL_ERR_NEW: begin
        op_a = OpAW'(alpha_inv);
        op_b = OpBW'(err_q);
      end
      MUL_FILT_OLD: begin
        op_a = OpAW'(alpha);
        op_b = OpBW'(filt_q);
      end
      MUL_HKP_ERR: begin
        op_a = OpAW'(cfg_i.heading_kp);
        op_b = OpBW'(e_q);
      end
      MUL_HKD_DIFF: begin
        op_a = OpAW'(cfg_i.heading_kd);
        op_b = OpBW'(e_diff);
      end
      MUL_SKP_FILT: begin
        op_a = OpAW'(cfg_i.speed_kp);
        op_b = OpBW'(filt_q);
      end
      MUL_SKI_INT: begin
        op_a = OpAW'(cfg_i.speed_ki);
        op_b = OpBW'(integ_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Truncation toward zero: bias negative sums before the shift.
  assign acc_bias16 = acc_q + (acc_q[ProdW-1] ? ProdW'(65535) : '0);
  assign acc_bias22 = acc_q + (acc_q[ProdW-1] ? ProdW'(4194303) : '0);

  assign integ_sum = OpBW'(integ_q) + OpBW'(filt_q);
  always_comb begin
    if (integ_sum > LimPos) begin
      integ_new = LimPos[IntegW-1:0];
    end else if (integ_sum < LimNeg) begin
      integ_new = LimNeg[IntegW-1:0];
    end else begin
      integ_new = integ_sum[IntegW-1:0];
    end
  end

  assign v_sat = sat16(acc_bias16[ProdW-1:16]);

  // Wheel mixing, limited to the upper bound first and then the lower one.
  assign upper_w  = (WordW+1)'(cfg_i.drive_upper);
  assign lower_w  = (WordW+1)'(cfg_i.drive_lower);
  assign left_w   = (WordW+1)'(v_sat) - (WordW+1)'(t_q);
  assign right_w  = (WordW+1)'(v_sat) + (WordW+1)'(t_q);
  assign left_hi  = (left_w > upper_w) ? upper_w : left_w;
  assign right_hi = (right_w > upper_w) ? upper_w : right_w;
  assign left_c   = (left_hi < lower_w) ? lower_w : left_hi;
  assign right_c  = (right_hi < lower_w) ? lower_w : right_hi;

  assign result_o = '{drive_left:  left_c[WordW-1:0],
                      drive_right: right_c[WordW-1:0],
                      speed_term:  v_sat,
                      turn_term:   t_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      integ_q  <= '0;
      prev_e_q <= '0;
    end else begin
      if (ctl_i.wb == WB_FILT) begin
        filt_q <= acc_bias16[ErrW+15:16];
      end
      if (ctl_i.wb == WB_INTEG) begin
        integ_q <= integ_new;
      end
      if (ctl_i.wb == WB_TURN) begin
        prev_e_q <= e_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    if (ctl_i.capture) begin
      err_q <= err_new;
      e_q   <= e_wrap[YawW-1:0];
    end
    unique case (ctl_i.acc_op)
      ACC_LOAD: acc_q <= prod_q;
      ACC_ADD:  acc_q <= acc_q + prod_q;
      default:  acc_q <= acc_q;
    endcase
    if (ctl_i.wb == WB_TURN) begin
      // The shifted sum is signed, so it is sign-extended before saturation.
      t_q <= sat16(26'($signed(acc_bias22[ProdW-1:22])));
    end
  end

  // The integral never leaves its clamp window.
  a_integ_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (OpBW'(integ_q) <= LimPos) && (OpBW'(integ_q) >= LimNeg))
    else $error("speed integral outside its limit");

  // A weighted mean of bounded errors stays within the error range.
  a_filt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filt_q <= 18'sd98304) && (filt_q >= -18'sd98304))
    else $error("filtered error outside the speed error range");

  // The stored heading error is always wrapped.
  a_prev_wrapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (prev_e_q <= 15'sd11520) && (prev_e_q >= -15'sd11520))
    else $error("stored heading error not wrapped");

endmodule

// ===== rtl/differential_drive_speed_heading_ctrl.sv =====
// ----------------------------------------------------------------------------
// Differential drive speed and heading controller
// Per control tick: low-pass filtered speed PI and wrapped heading PD,
// mixed into clamped left and right wheel drive values.
// ----------------------------------------------------------------------------
// Usage:
//   One item on the s_axis channel is one control tick (speed target, two
//   encoder counts, measured yaw). Each item yields exactly one result item
//   on the m_axis channel (both wheel drives plus the speed and turn terms).
//   The cfg channel writes the gain, target and clamp registers; write it
//   only while no item is in flight. cfg_ready_o is always high.
// Sequencing:
//   A small microcoded sequencer steps through a nine-word control program
//   that drives one shared 23x19 multiplier and an accumulator. An item is
//   taken in step zero, and its result is loaded into the output register in
//   the final step. The next item is taken only once the program is back in
//   step zero, so items are processed one at a time.
// Reset and stalls:
//   Reset restores the register defaults and clears the filter, integral
//   and previous heading error. The output register holds a finished result
//   while the receiver stalls; the next item is still taken and computed,
//   and the sequencer waits in its final step until the output slot frees.
// ----------------------------------------------------------------------------
module differential_drive_speed_heading_ctrl #(
  parameter int IntegralLimit = 1000
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // [15:0] speed_target, [31:16] count_left, [47:32] count_right,
  // [62:48] yaw_now, [63] zero
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [63:0]                 s_axis_tdata,
  // [15:0] drive_left, [31:16] drive_right, [47:32] speed_term,
  // [63:48] turn_term
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dshc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [dshc_pkg::GainW-1:0]  cfg_data_i
);
  import dshc_pkg::*;

  step_t     step_q;
  step_t     step_d;
  uword_t    uw;
  ctl_t      ctl;
  cfg_t      cfg_q;
  in_item_t  item;
  out_item_t result;
  logic      in_acc;
  logic      out_free;
  logic      out_load;
  logic      m_valid_q;
  logic      m_valid_d;
  logic [63:0] m_data_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_kp       <= 22'd249037;
      cfg_q.speed_ki       <= 22'd328;
      cfg_q.filter_alpha   <= 17'd45875;
      cfg_q.heading_kp     <= 22'd917504;
      cfg_q.heading_kd     <= 22'd655360;
      cfg_q.heading_target <= '0;
      cfg_q.drive_upper    <= 16'sd800;
      cfg_q.drive_lower    <= -16'sd800;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SPEED_KP:       cfg_q.speed_kp       <= cfg_data_i;
        REG_SPEED_KI:       cfg_q.speed_ki       <= cfg_data_i;
        REG_FILTER_ALPHA:   cfg_q.filter_alpha   <= cfg_data_i[AlphaW-1:0];
        REG_HEADING_KP:     cfg_q.heading_kp     <= cfg_data_i;
        REG_HEADING_KD:     cfg_q.heading_kd     <= cfg_data_i;
        REG_HEADING_TARGET: cfg_q.heading_target <= cfg_data_i[YawW-1:0];
        REG_DRIVE_UPPER:    cfg_q.drive_upper    <= cfg_data_i[WordW-1:0];
        REG_DRIVE_LOWER:    cfg_q.drive_lower    <= cfg_data_i[WordW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: the control word of the current step, and the step counter
  // with its two conditional jumps (wait for an item, wait for the output).
  assign uw       = ucode(step_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (uw.wb == WB_OUT) && out_free;

  assign s_axis_tready = (step_q == '0);

  always_comb begin
    unique case (uw.jmp)
      JMP_NEXT:    step_d = step_q + 4'd1;
      JMP_WAIT_IN: step_d = in_acc ? step_q + 4'd1 : step_q;
      JMP_DONE:    step_d = out_free ? uw.target : step_q;
      default:     step_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctl = '{capture: in_acc, mul_sel: uw.mul_sel, acc_op: uw.acc_op, wb: uw.wb};

  assign item = '{speed_target: s_axis_tdata[15:0],
                  count_left:   s_axis_tdata[31:16],
                  count_right:  s_axis_tdata[47:32],
                  yaw_now:      s_axis_tdata[62:48]};

  dshc_datapath #(
    .IntegralLimit(IntegralLimit)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .item_i   (item),
    .result_o (result)
  );

  // Output register: holds one finished result while the receiver stalls.
  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {result.turn_term, result.speed_term,
                   result.drive_right, result.drive_left};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // An accepted item always starts the program at its first working step.
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (step_q == StepFirst))
    else $error("program did not start after an accepted item");

  // A new result only appears out of the final program step.
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(step_q) == StepLast))
    else $error("result loaded outside the final step");

  // The step counter never runs past the end of the program.
  a_step_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepLast)
    else $error("step counter beyond the program");

endmodule
